[rtl/cpne_pkg.sv]
// Shared types and constants for the character palette nibble encoder.
`default_nettype none

package cpne_pkg;

  localparam int PALETTE_SLOTS = 7;
  localparam int CODE_W        = 3;
  localparam int CHAR_W        = 8;
  localparam int POS_W         = 16;
  localparam int BASE_W        = 10;
  localparam int KIND_W        = 2;
  localparam int DATA_W        = 64;

  localparam logic [CODE_W-1:0] LAST_SLOT = CODE_W'(PALETTE_SLOTS - 1);
  localparam logic [CODE_W-1:0] LINE_CODE = 3'd7;

  localparam logic [CHAR_W-1:0] CH_RETURN = 8'd13;
  localparam logic [CHAR_W-1:0] CH_FEED   = 8'd10;
  localparam logic [CHAR_W-1:0] PRINT_LOW = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_END = 8'd126;

  localparam logic [BASE_W-1:0] BASE_RESET = 10'd20;

  typedef enum logic [KIND_W-1:0] {
    KIND_SYMBOL  = 2'd0,
    KIND_UNKNOWN = 2'd1,
    KIND_PALETTE = 2'd2
  } kind_t;

  typedef struct packed {
    logic write_en;
    logic clear;
  } pal_ctrl_t;

  typedef struct packed {
    logic [CODE_W-1:0] slot;
    logic              full;
  } pal_hit_t;

  typedef struct packed {
    logic [POS_W-1:0]  symbol_count;
    logic [CHAR_W-1:0] palette_char;
    logic [CODE_W-1:0] palette_slot;
    logic              palette_full;
    logic              high_nibble;
    logic [POS_W-1:0]  byte_address;
    logic [POS_W-1:0]  position;
    logic [CODE_W-1:0] code;
  } res_data_t;

endpackage

`default_nettype wire

[rtl/char_palette_nibble_encoder.sv]
// Top level: character stream to palette nibble codes with session dump.
//
//   channel   signals                         direction  word
//   s_axis    s_tvalid s_tready s_tdata       in         one received character
//   m_axis    m_tvalid m_tready m_tdata ...   out        one code or palette entry
//   cfg       cfg_valid cfg_ready cfg_data    in         header_base register
//
// One character per cycle while the output is not stalled: an input register,
// the parallel palette compare, and an output register. A session end (line
// feed or a second return) emits PALETTE_SLOTS words, input stalled meanwhile.
// Reset empties the palette, clears the position and sets header_base to 20.
// A stalled output holds the input register; s_tready drops in the same cycle
// once that register holds a word.
`default_nettype none

module char_palette_nibble_encoder import cpne_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [CHAR_W-1:0] s_tdata,   // char_in[7:0]
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DATA_W-1:0]      m_tdata,   // code[2:0] position[18:3] byte_address[34:19]
                                            // high_nibble[35] palette_full[36]
                                            // palette_slot[39:37] palette_char[47:40]
                                            // symbol_count[63:48]
  output logic [KIND_W-1:0]      m_tuser,   // kind[1:0]
  output logic                   m_tlast,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [BASE_W-1:0] cfg_data
);

  logic              char_valid;
  logic [CHAR_W-1:0] char_q;
  logic              last_was_return;
  logic [POS_W-1:0]  position;
  logic [BASE_W-1:0] header_base;
  logic              emitting;
  logic [CODE_W-1:0] emit_idx;

  logic              is_cr, is_lf, is_print, session_end;
  logic              out_free, go, emit_go, emit_done, advance;
  logic [CODE_W-1:0] rd_slot;
  logic [CHAR_W-1:0] rd_char;
  pal_ctrl_t         pal_ctrl;
  pal_hit_t          pal_hit;

  res_data_t         res_next;
  kind_t             kind_next;
  logic              last_next;

  assign cfg_ready = 1'b1;

  assign is_cr       = (char_q == CH_RETURN);
  assign is_lf       = (char_q == CH_FEED);
  assign is_print    = (char_q >= PRINT_LOW) && (char_q < PRINT_END);
  assign session_end = is_lf || (is_cr && last_was_return);

  assign out_free  = !m_tvalid || m_tready;
  assign go        = char_valid && !emitting && out_free;
  assign emit_go   = emitting && out_free;
  assign emit_done = (emit_go && emit_idx == LAST_SLOT) ||
                     (go && session_end && LAST_SLOT == '0);
  assign advance   = go && ((is_cr && !last_was_return) || is_print);
  assign s_tready  = !char_valid || go;
  assign rd_slot   = emitting ? emit_idx : '0;

  assign pal_ctrl.write_en = go && is_print;
  assign pal_ctrl.clear    = emit_done;

  cpne_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (pal_ctrl),
    .char_in (char_q),
    .rd_slot (rd_slot),
    .hit     (pal_hit),
    .rd_char (rd_char)
  );

  always_comb begin
    res_next  = '0;
    kind_next = KIND_UNKNOWN;
    last_next = 1'b1;
    if (emitting || session_end) begin
      kind_next             = KIND_PALETTE;
      res_next.palette_slot = rd_slot;
      res_next.palette_char = rd_char;
      res_next.symbol_count = position;
      last_next             = (rd_slot == LAST_SLOT);
    end else if (is_cr || is_print) begin
      kind_next             = KIND_SYMBOL;
      res_next.code         = is_cr ? LINE_CODE : pal_hit.slot;
      res_next.palette_full = is_print && pal_hit.full;
      res_next.position     = position;
      res_next.byte_address = POS_W'(header_base) + POS_W'(position[POS_W-1:1]);
      res_next.high_nibble  = position[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (s_tready) begin
      char_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      char_q <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || emit_done) begin
      position        <= '0;
      last_was_return <= 1'b0;
    end else begin
      if (advance) begin
        position <= position + 1'b1;
      end
      if (go && is_cr) begin
        last_was_return <= 1'b1;
      end else if (go && is_print) begin
        last_was_return <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      emit_idx <= '0;
    end else if (emit_go) begin
      if (emit_idx == LAST_SLOT) begin
        emitting <= 1'b0;
        emit_idx <= '0;
      end else begin
        emit_idx <= emit_idx + 1'b1;
      end
    end else if (go && session_end && LAST_SLOT != '0) begin
      emitting <= 1'b1;
      emit_idx <= CODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= go || emit_go;
    end
    if (out_free && (go || emit_go)) begin
      m_tdata <= DATA_W'(res_next);
      m_tuser <= kind_next;
      m_tlast <= last_next;
    end
  end

endmodule

`default_nettype wire

[rtl/cpne_palette.sv]
// Palette store with parallel match and first-free-slot allocation.
`default_nettype none

module cpne_palette import cpne_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pal_ctrl_t         ctrl,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic [CODE_W-1:0] rd_slot,
  output pal_hit_t               hit,
  output logic [CHAR_W-1:0]      rd_char
);

  logic [CHAR_W-1:0] store [PALETTE_SLOTS];

  always_comb begin
    hit.slot = LINE_CODE;
    hit.full = 1'b1;
    for (int s = PALETTE_SLOTS - 1; s >= 0; s--) begin
      if (store[s] == char_in || store[s] == '0) begin
        hit.slot = CODE_W'(s);
        hit.full = 1'b0;
      end
    end
  end

  always_comb begin
    rd_char = '0;
    for (int s = 0; s < PALETTE_SLOTS; s++) begin
      if (rd_slot == CODE_W'(s)) begin
        rd_char = store[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int s = 0; s < PALETTE_SLOTS; s++) begin
        store[s] <= '0;
      end
    end else if (ctrl.write_en && !hit.full) begin
      for (int s = 0; s < PALETTE_SLOTS; s++) begin
        if (hit.slot == CODE_W'(s)) begin
          store[s] <= char_in;
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/cpne_checker.sv]
// Checker for the character palette nibble encoder: predicts output words and compares them.
`default_nettype none

module cpne_checker import cpne_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [CHAR_W-1:0] s_tdata,
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [DATA_W-1:0] m_tdata,
  input  wire logic [KIND_W-1:0] m_tuser,
  input  wire logic              m_tlast,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [BASE_W-1:0] cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef struct {
    kind_t     kind;
    res_data_t data;
    logic      last;
  } word_t;

  word_t             expected_words[$];
  logic [CHAR_W-1:0] palette [PALETTE_SLOTS];
  bit                after_return;
  logic [POS_W-1:0]  next_pos;
  logic [BASE_W-1:0] header_base;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic push_symbol(input logic [CODE_W-1:0] code, input logic full);
    word_t w;
    w.kind = KIND_SYMBOL;
    w.data = '0;
    w.data.code = code;
    w.data.position = next_pos;
    w.data.byte_address = POS_W'(header_base) + (next_pos >> 1);
    w.data.high_nibble = next_pos[0];
    w.data.palette_full = full;
    w.last = 1'b1;
    expected_words.push_back(w);
    next_pos = next_pos + 1'b1;
  endtask

  task automatic dump_palette();
    word_t w;
    for (int s = 0; s < PALETTE_SLOTS; s++) begin
      w.kind = KIND_PALETTE;
      w.data = '0;
      w.data.palette_slot = CODE_W'(s);
      w.data.palette_char = palette[s];
      w.data.symbol_count = next_pos;
      w.last = (s == PALETTE_SLOTS - 1);
      expected_words.push_back(w);
    end
    palette = '{default: '0};
    after_return = 1'b0;
    next_pos = '0;
  endtask

  task automatic encode_char(input logic [CHAR_W-1:0] c);
    logic [CODE_W-1:0] code;
    logic              full;
    word_t             w;
    if (c == CH_RETURN) begin
      if (after_return) begin
        dump_palette();
      end else begin
        push_symbol(LINE_CODE, 1'b0);
        after_return = 1'b1;
      end
    end else if (c == CH_FEED) begin
      dump_palette();
    end else if (c >= PRINT_LOW && c < PRINT_END) begin
      code = LINE_CODE;
      full = 1'b1;
      for (int s = 0; s < PALETTE_SLOTS; s++) begin
        if (full && (palette[s] == c || palette[s] == '0)) begin
          palette[s] = c;
          code = CODE_W'(s);
          full = 1'b0;
        end
      end
      push_symbol(code, full);
      after_return = 1'b0;
    end else begin
      w.kind = KIND_UNKNOWN;
      w.data = '0;
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endtask

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic compare_word();
    word_t     e;
    res_data_t got;
    got = res_data_t'(m_tdata);
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual kind %0d data %h",
               $time, m_tuser, m_tdata);
      fail_count++;
    end else begin
      e = expected_words.pop_front();
      check_field("kind", e.kind, m_tuser);
      check_field("code", e.data.code, got.code);
      check_field("position", e.data.position, got.position);
      check_field("byte_address", e.data.byte_address, got.byte_address);
      check_field("high_nibble", e.data.high_nibble, got.high_nibble);
      check_field("palette_full", e.data.palette_full, got.palette_full);
      check_field("palette_slot", e.data.palette_slot, got.palette_slot);
      check_field("palette_char", e.data.palette_char, got.palette_char);
      check_field("symbol_count", e.data.symbol_count, got.symbol_count);
      check_field("last", e.last, m_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      palette = '{default: '0};
      after_return = 1'b0;
      next_pos = '0;
      header_base = BASE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        header_base = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        compare_word();
      end
      if (s_tvalid && s_tready) begin
        encode_char(s_tdata);
      end
    end
    pending = expected_words.size();
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench top for the character palette nibble encoder: stimulus, flow control and verdict.
`default_nettype none

module testbench import cpne_pkg::*;;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int MODE_NARROW = 0;
  localparam int MODE_WIDE   = 1;
  localparam int MODE_NOISE  = 2;
  localparam logic [CHAR_W-1:0] NARROW_BASE = 8'd65;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0] m_tuser;
  logic              m_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BASE_W-1:0] cfg_data = '0;
  int                fail_count;
  int                pending;

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;

  logic [CHAR_W-1:0] directed [25] = '{
    PRINT_LOW, 8'd125, PRINT_END, 8'd31, 8'd0, 8'd255, PRINT_LOW, CH_RETURN, 8'd65,
    CH_RETURN, CH_RETURN, CH_FEED,
    8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
    CH_RETURN, 8'd128, CH_RETURN, 8'd120, CH_FEED
  };

  char_palette_nibble_encoder u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  cpne_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_char(input logic [CHAR_W-1:0] c);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sessions of random length: narrow alphabet repeats slots, wide one fills the palette
  task automatic play_phase(input int budget);
    int                used;
    int                mode;
    int                n;
    int                r;
    logic [CHAR_W-1:0] c;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(0, 9);
      mode = (r < 5) ? MODE_NARROW : (r < 9) ? MODE_WIDE : MODE_NOISE;
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (mode == MODE_NOISE) begin
          c = CHAR_W'($urandom_range(0, 255));
        end else if (r < 8) begin
          c = CH_RETURN;
        end else if (r < 15) begin
          do c = CHAR_W'($urandom_range(0, 255));
          while ((c >= PRINT_LOW && c < PRINT_END) || c == CH_RETURN || c == CH_FEED);
        end else if (mode == MODE_NARROW) begin
          c = NARROW_BASE + CHAR_W'($urandom_range(0, 8));
        end else begin
          c = CHAR_W'($urandom_range(PRINT_LOW, PRINT_END - 1));
        end
        send_char(c);
      end
      used += n;
      if (mode != MODE_NOISE) begin
        if ($urandom_range(0, 1) == 0) begin
          send_char(CH_FEED);
          used += 1;
        end else begin
          send_char(CH_RETURN);
          send_char(CH_RETURN);
          used += 2;
        end
      end
    end
  endtask

  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (!rst);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_char(directed[i]);

    write_base(10'd1023);
    play_phase(105);

    write_base(10'd0);
    hold_req = 1'b1;
    play_phase(105);

    write_base(BASE_W'($urandom_range(1, 1022)));
    @(negedge clk);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    play_phase(105);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
